[src/bsc_pkg.sv]
package bsc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP_CALIB  = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW   = 3'd1;
  localparam logic [2:0] REG_PRESS_HIGH  = 3'd2;
  localparam logic [2:0] REG_PRESS_LAST  = 3'd3;
  localparam logic [2:0] REG_SEA_SCALE   = 3'd4;

  localparam logic [17:0] SCALE_RESET    = 18'd104518;
  // The scale denominator 100000 is 32 times this odd factor.
  localparam logic [11:0] SCALE_DIV_ODD  = 12'd3125;
  // Reciprocal of 3125 with a 40-bit shift, exact for all 28-bit values.
  localparam logic [28:0] RECIP_3125     = 29'd351843721;
  localparam logic [31:0] TEMP_OFFSET    = 32'd64000;
  localparam logic [31:0] RAW_FULL_SCALE = 32'd1048576;
  localparam logic [31:0] PRESS_FACTOR   = 32'd3125;
  localparam logic [31:0] ROUND_HALF     = 32'd128;
  localparam logic [31:0] P1_BIAS        = 32'd32768;
  // Reciprocal of ten with a 35-bit shift, exact for all 32-bit values.
  localparam logic [31:0] RECIP_TEN      = 32'hCCCCCCCD;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

endpackage

[src/barometric_sensor_compensation.sv]
// Integer temperature and pressure compensation for a barometric sensor. Each input beat
// carries one raw temperature and one raw pressure reading; each output beat carries the
// compensated temperature (hundredths and tenths of a degree), the sea-level scaled pressure
// (pascals and tenths of hPa) and a flag for a zero pressure divisor. The block takes one
// beat per clock while the pipeline moves. A result beat passes through 56 pipeline stages,
// the first loaded by the edge that accepts its input beat, and then the output register.
// Most of the depth is the restoring divider for the pressure quotient, one quotient bit per
// stage over 32 stages; the scaling by 1/100000 is a reciprocal multiplication in 16-bit
// digits. The whole pipeline holds only while its last stage and the output register both hold
// results and the output beat is not taken. The user must write calibration words through
// the configuration channel while no reading is in flight; the block does not enforce this.
module barometric_sensor_compensation (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // raw_temperature [19:0], raw_pressure [39:20]
  output logic         m_tvalid,
  input  logic         m_tready,
  // temperature_hundredths [31:0], temperature_tenths [47:32],
  // pressure_pascal [79:48], pressure_tenth_hpa [95:80]
  output logic [95:0]  m_tdata,
  output logic         m_tuser,   // divisor_was_zero [0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int LAT = 56;

  logic [47:0] temp_calib_words;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_last;
  logic [17:0] sea_level_scale;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic           en;
  logic           pv;
  logic [LAT-1:0] vld;
  logic           out_v;

  // Front stages.
  logic [31:0] s1_x1, s1_d;
  logic [19:0] adcp [0:8];
  logic [31:0] s2_m1, s2_dd;
  logic [31:0] s3_a, s3_e;
  logic [31:0] s4_a, s4_m2;
  logic [31:0] s5_fine;
  logic [31:0] s6_pa;
  logic [31:0] s7_q, s7_ap5, s7_ap2;
  logic [31:0] s8_b1, s8_b2, s8_m3, s8_ap2;
  logic [31:0] s9_b, s9_a2;
  logic [31:0] s10_v, s10_x;
  logic [31:0] s11_den, s11_pp;

  // Temperature side path.
  logic [31:0] temp_c  [5:LAT-1];
  logic [31:0] t_mag;
  logic [63:0] t_prod;
  logic [15:0] tenth_c [8:LAT-1];
  logic        zero_c  [11:LAT-1];

  // Pressure quotient divider.
  logic [31:0] d1_rem [0:32];
  logic [31:0] d1_dq  [0:32];
  logic [31:0] d1_den [0:32];
  logic        d1_dbl [0:32];
  logic [32:0] d1_sh  [0:31];
  logic        d1_ge  [0:31];

  // Back stages.
  logic [31:0] p_a, p_b, p_c, p_fin;
  logic [31:0] s45_sq, s45_m4, s46_a3, s46_b3;

  // Division by the scale denominator.
  logic [49:0] sc_prod;
  logic [12:0] dv0;
  logic [31:0] dy0;
  logic [41:0] dm0;
  logic [27:0] dv1, dv1_d, dv2;
  logic [15:0] dy1, dy2;
  logic [56:0] dm1, dm2;
  logic [15:0] dq1, dq1_d;

  logic [31:0] pa_r, pa_f;
  logic [63:0] pa_m;

  assign t1 = {16'b0, temp_calib_words[15:0]};
  assign t2 = bsc_pkg::sx16(temp_calib_words[31:16]);
  assign t3 = bsc_pkg::sx16(temp_calib_words[47:32]);
  assign p1 = {16'b0, press_calib_low[15:0]};
  assign p2 = bsc_pkg::sx16(press_calib_low[31:16]);
  assign p3 = bsc_pkg::sx16(press_calib_low[47:32]);
  assign p4 = bsc_pkg::sx16(press_calib_low[63:48]);
  assign p5 = bsc_pkg::sx16(press_calib_high[15:0]);
  assign p6 = bsc_pkg::sx16(press_calib_high[31:16]);
  assign p7 = bsc_pkg::sx16(press_calib_high[47:32]);
  assign p8 = bsc_pkg::sx16(press_calib_high[63:48]);
  assign p9 = bsc_pkg::sx16(press_calib_last);

  // The pipeline moves unless its last stage holds a result that cannot leave.
  assign pv        = vld[LAT-1];
  assign en        = !pv || !out_v || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib_words <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_last <= '0;
      sea_level_scale  <= bsc_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bsc_pkg::REG_TEMP_CALIB: temp_calib_words <= cfg_data[47:0];
        bsc_pkg::REG_PRESS_LOW:  press_calib_low  <= cfg_data;
        bsc_pkg::REG_PRESS_HIGH: press_calib_high <= cfg_data;
        bsc_pkg::REG_PRESS_LAST: press_calib_last <= cfg_data[15:0];
        bsc_pkg::REG_SEA_SCALE:  sea_level_scale  <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      out_v <= 1'b0;
    end else begin
      if (en) vld <= {vld[LAT-2:0], s_tvalid};
      if (en && pv) out_v <= 1'b1;
      else if (m_tready) out_v <= 1'b0;
    end
  end

  always_comb begin
    for (int j = 0; j < 32; j++) begin
      d1_sh[j] = {d1_rem[j], d1_dq[j][31]};
      d1_ge[j] = d1_sh[j] >= {1'b0, d1_den[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Fine temperature.
      s1_x1   <= {15'b0, s_tdata[19:3]} - {15'b0, t1[15:0], 1'b0};
      s1_d    <= {16'b0, s_tdata[19:4]} - t1;
      adcp[0] <= s_tdata[39:20];
      for (int k = 1; k < 9; k++) adcp[k] <= adcp[k-1];
      s2_m1   <= s1_x1 * t2;
      s2_dd   <= s1_d * s1_d;
      s3_a    <= bsc_pkg::asr32(s2_m1, 11);
      s3_e    <= bsc_pkg::asr32(s2_dd, 12);
      s4_a    <= s3_a;
      s4_m2   <= s3_e * t3;
      s5_fine <= s4_a + bsc_pkg::asr32(s4_m2, 14);

      // Temperature outputs.
      temp_c[5] <= bsc_pkg::asr32(s5_fine * 32'd5 + bsc_pkg::ROUND_HALF, 8);
      for (int k = 6; k < LAT; k++) temp_c[k] <= temp_c[k-1];
      t_mag  <= temp_c[5][31] ? 32'(-temp_c[5]) : temp_c[5];
      t_prod <= {32'b0, t_mag} * {32'b0, bsc_pkg::RECIP_TEN};
      tenth_c[8] <= temp_c[7][31] ? 16'(-t_prod[50:35]) : t_prod[50:35];
      for (int k = 9; k < LAT; k++) tenth_c[k] <= tenth_c[k-1];

      // Pressure divisor and dividend.
      s6_pa  <= bsc_pkg::asr32(s5_fine, 1) - bsc_pkg::TEMP_OFFSET;
      s7_q   <= bsc_pkg::asr32(s6_pa, 2) * bsc_pkg::asr32(s6_pa, 2);
      s7_ap5 <= s6_pa * p5;
      s7_ap2 <= p2 * s6_pa;
      s8_b1  <= bsc_pkg::asr32(s7_q, 11) * p6;
      s8_b2  <= {s7_ap5[30:0], 1'b0};
      s8_m3  <= p3 * bsc_pkg::asr32(s7_q, 13);
      s8_ap2 <= s7_ap2;
      s9_b   <= bsc_pkg::asr32(s8_b1 + s8_b2, 2) + {p4[15:0], 16'b0};
      s9_a2  <= bsc_pkg::asr32(bsc_pkg::asr32(s8_m3, 3) + bsc_pkg::asr32(s8_ap2, 1), 18);
      s10_v  <= (bsc_pkg::P1_BIAS + s9_a2) * p1;
      s10_x  <= (bsc_pkg::RAW_FULL_SCALE - {12'b0, adcp[8]}) - bsc_pkg::asr32(s9_b, 12);
      s11_den <= bsc_pkg::asr32(s10_v, 15);
      s11_pp  <= s10_x * bsc_pkg::PRESS_FACTOR;

      zero_c[11] <= (s11_den == '0);
      for (int k = 12; k < LAT; k++) zero_c[k] <= zero_c[k-1];

      // A dividend with its top bit set is divided first and doubled afterwards.
      d1_rem[0] <= '0;
      d1_dq[0]  <= s11_pp[31] ? s11_pp : {s11_pp[30:0], 1'b0};
      d1_den[0] <= s11_den;
      d1_dbl[0] <= s11_pp[31];
      for (int j = 0; j < 32; j++) begin
        d1_rem[j+1] <= d1_ge[j] ? 32'(d1_sh[j] - {1'b0, d1_den[j]}) : d1_sh[j][31:0];
        d1_dq[j+1]  <= {d1_dq[j][30:0], d1_ge[j]};
        d1_den[j+1] <= d1_den[j];
        d1_dbl[j+1] <= d1_dbl[j];
      end

      // Second-order pressure correction.
      p_a    <= d1_dbl[32] ? {d1_dq[32][30:0], 1'b0} : d1_dq[32];
      s45_sq <= {3'b0, p_a[31:3]} * {3'b0, p_a[31:3]};
      s45_m4 <= {2'b0, p_a[31:2]} * p8;
      p_b    <= p_a;
      s46_a3 <= bsc_pkg::asr32(p9 * {13'b0, s45_sq[31:13]}, 12);
      s46_b3 <= bsc_pkg::asr32(s45_m4, 13);
      p_c    <= p_b;
      p_fin  <= p_c + bsc_pkg::asr32(s46_a3 + s46_b3 + p7, 4);

      // Sea-level scaling. Dividing by 100000 is a shift by five and then a long
      // division by 3125 in 16-bit digits, each digit found by a reciprocal multiply.
      // Only the two low quotient digits reach the 32-bit result.
      sc_prod <= {18'b0, p_fin} * {32'b0, sea_level_scale};
      dv0     <= sc_prod[49:37];
      dy0     <= sc_prod[36:5];
      dm0     <= {29'b0, sc_prod[49:37]} * {13'b0, bsc_pkg::RECIP_3125};
      dv1     <= {12'(dv0 - {11'b0, dm0[41:40]} * {1'b0, bsc_pkg::SCALE_DIV_ODD}),
                  dy0[31:16]};
      dy1     <= dy0[15:0];
      dm1     <= {29'b0, dv1} * {28'b0, bsc_pkg::RECIP_3125};
      dv1_d   <= dv1;
      dy2     <= dy1;
      dq1     <= dm1[55:40];
      dv2     <= {12'(dv1_d - {12'b0, dm1[55:40]} * {16'b0, bsc_pkg::SCALE_DIV_ODD}), dy2};
      dm2     <= {29'b0, dv2} * {28'b0, bsc_pkg::RECIP_3125};
      dq1_d   <= dq1;

      pa_r <= zero_c[53] ? '0 : {dq1_d, dm2[55:40]};
      pa_f <= pa_r;
      pa_m <= {32'b0, pa_r} * {32'b0, bsc_pkg::RECIP_TEN};
    end
  end

  always_ff @(posedge clk) begin
    if (en && pv) begin
      m_tdata <= {pa_m[50:35], pa_f, tenth_c[LAT-1], temp_c[LAT-1]};
      m_tuser <= zero_c[LAT-1];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[79:48] == '0)
    else $error("zero divisor flagged with nonzero pressure");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[95:80] == '0)
    else $error("zero divisor flagged with nonzero tenth hPa");

  assert property (@(posedge clk) disable iff (rst)
    out_v && !m_tready && pv |=> $stable(vld))
    else $error("pipeline moved while its last result was blocked");

endmodule

[test/tb_barometric_sensor_compensation.sv]
`timescale 1ns / 1ps

module tb_barometric_sensor_compensation;

  localparam int PIPE_LATENCY = 57;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } reading_t;

  typedef struct {
    logic [31:0] temp_c100;
    logic [15:0] temp_c10;
    logic [31:0] press_pa;
    logic [15:0] press_dhpa;
    logic        div_zero;
  } compensated_t;

  // One row of the directed table; has_known marks a result typed in by hand.
  typedef struct {
    reading_t     rd;
    bit           has_known;
    compensated_t known;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [47:0] cal_t;
  logic [63:0] cal_pl;
  logic [63:0] cal_ph;
  logic [15:0] cal_p9;
  logic [17:0] sea_scale;

  compensated_t pending_readings[$];
  int  fail_count = 0;
  int  hold_off = 0;
  int  beats_taken = 0;
  int  beats_seen = 0;
  int  rx_wait = 0;
  bit  sending_done = 1'b0;

  barometric_sensor_compensation dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("barometric_sensor_compensation test failed");
    $finish;
  end

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic compensated_t compensate(input reading_t rd);
    compensated_t r;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] x, y, d, q, fine, temp, p, pa;
    logic [63:0] wide;
    t1 = {16'd0, cal_t[15:0]};
    t2 = sext(cal_t[31:16]);
    t3 = sext(cal_t[47:32]);
    p1 = {16'd0, cal_pl[15:0]};
    p2 = sext(cal_pl[31:16]);
    p3 = sext(cal_pl[47:32]);
    p4 = sext(cal_pl[63:48]);
    p5 = sext(cal_ph[15:0]);
    p6 = sext(cal_ph[31:16]);
    p7 = sext(cal_ph[47:32]);
    p8 = sext(cal_ph[63:48]);
    p9 = sext(cal_p9);
    x = sra(32'((({12'd0, rd.raw_t} >> 3) - (t1 << 1)) * t2), 11);
    d = ({12'd0, rd.raw_t} >> 4) - t1;
    y = sra(32'(sra(32'(d * d), 12) * t3), 14);
    fine = x + y;
    temp = sra(32'(fine * 32'd5) + 32'd128, 8);
    x = sra(fine, 1) - 32'd64000;
    q = 32'(sra(x, 2) * sra(x, 2));
    y = 32'(sra(q, 11) * p6);
    y = y + 32'(32'(x * p5) * 32'd2);
    y = sra(y, 2) + (p4 << 16);
    x = sra(sra(32'(p3 * sra(q, 13)), 3) + sra(32'(p2 * x), 1), 18);
    x = sra(32'((32'd32768 + x) * p1), 15);
    r.div_zero = (x == 0);
    pa = 0;
    if (!r.div_zero) begin
      p = 32'(((32'd1048576 - {12'd0, rd.raw_p}) - sra(y, 12)) * 32'd3125);
      if (!p[31]) p = (p << 1) / x;
      else p = 32'((p / x) * 32'd2);
      x = sra(32'(p9 * (32'((p >> 3) * (p >> 3)) >> 13)), 12);
      y = sra(32'((p >> 2) * p8), 13);
      p = p + sra(x + y + p7, 4);
      wide = (64'(p) * 64'(sea_scale)) / 64'd100000;
      pa = wide[31:0];
    end
    r.temp_c100 = temp;
    r.temp_c10 = 16'($signed(temp) / 10);
    r.press_pa = pa;
    r.press_dhpa = 16'(pa / 10);
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      bsc_pkg::REG_TEMP_CALIB: cal_t = val[47:0];
      bsc_pkg::REG_PRESS_LOW: cal_pl = val;
      bsc_pkg::REG_PRESS_HIGH: cal_ph = val;
      bsc_pkg::REG_PRESS_LAST: cal_p9 = val[15:0];
      bsc_pkg::REG_SEA_SCALE: sea_scale = val[17:0];
      default: ;
    endcase
  endtask

  // Ends a run of readings and waits until every result has come back.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The valid stays high after the beat; the next call or drain decides what follows.
  task automatic send_reading(input reading_t rd, input bit has_known,
                              input compensated_t known);
    compensated_t e;
    int gap;
    gap = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    e = compensate(rd);
    if (has_known && (e.temp_c100 != known.temp_c100 || e.temp_c10 != known.temp_c10 ||
                      e.press_pa != known.press_pa || e.press_dhpa != known.press_dhpa ||
                      e.div_zero != known.div_zero)) begin
      $error("directed row disagrees with predictor for raw %h", rd);
      fail_count++;
    end
    pending_readings.push_back(has_known ? known : e);
    s_tdata <= {rd.raw_p, rd.raw_t};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Typical factory calibration words for this sensor family.
  task automatic load_typical;
    write_reg(bsc_pkg::REG_TEMP_CALIB, {16'd0, 16'hFE18, 16'd26435, 16'd27504});
    write_reg(bsc_pkg::REG_PRESS_LOW, {16'd2855, 16'h0BD0, 16'hD7D0, 16'd36477});
    write_reg(bsc_pkg::REG_PRESS_HIGH, {16'hEA0C, 16'd15500, 16'hFFF9, 16'd140});
    write_reg(bsc_pkg::REG_PRESS_LAST, 64'd6000);
  endtask

  function automatic reading_t rand_reading(input bit plausible);
    reading_t rd;
    if (plausible) begin
      rd.raw_t = 20'($urandom_range(400000, 600000));
      rd.raw_p = 20'($urandom_range(200000, 700000));
    end else begin
      rd.raw_t = 20'($urandom);
      rd.raw_p = 20'($urandom);
    end
    return rd;
  endfunction

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++)
      send_reading(rand_reading($urandom_range(0, 3) != 0), 0, '{default: 0});
  endtask

  // Output side: a fresh random wait after every beat taken, and a long hold-off when one
  // is requested.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      if (beats_seen != beats_taken) begin
        beats_seen = beats_taken;
        rx_wait = $urandom_range(0, 10);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    compensated_t e;
    if (!rst && m_tvalid && m_tready) begin
      beats_taken++;
      if (pending_readings.size() == 0) begin
        $error("result beat with no reading outstanding");
        fail_count++;
      end else begin
        e = pending_readings.pop_front();
        if (m_tdata[31:0] !== e.temp_c100) begin
          $error("temperature_hundredths expected %h got %h", e.temp_c100, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[47:32] !== e.temp_c10) begin
          $error("temperature_tenths expected %h got %h", e.temp_c10, m_tdata[47:32]);
          fail_count++;
        end
        if (m_tdata[79:48] !== e.press_pa) begin
          $error("pressure_pascal expected %h got %h", e.press_pa, m_tdata[79:48]);
          fail_count++;
        end
        if (m_tdata[95:80] !== e.press_dhpa) begin
          $error("pressure_tenth_hpa expected %h got %h", e.press_dhpa, m_tdata[95:80]);
          fail_count++;
        end
        if (m_tuser !== e.div_zero) begin
          $error("divisor_was_zero expected %b got %b", e.div_zero, m_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t table_rows[$];
    row_t r;
    int guard;
    cal_t = '0;
    cal_pl = '0;
    cal_ph = '0;
    cal_p9 = '0;
    sea_scale = bsc_pkg::SCALE_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset every calibration word is zero, so P1 is zero and the divisor is zero.
    // With T1..T3 zero, fine temperature is 0 and temperature is 0.5 rounded down to 0.
    r.has_known = 1;
    r.known = '{temp_c100: 32'd0, temp_c10: 16'd0, press_pa: 32'd0, press_dhpa: 16'd0,
                div_zero: 1'b1};
    r.rd = '{20'd0, 20'd0};
    table_rows.push_back(r);
    r.rd = '{20'hFFFFF, 20'hFFFFF};
    table_rows.push_back(r);
    r.rd = '{20'hAAAAA, 20'h55555};
    table_rows.push_back(r);
    r.rd = '{20'h55555, 20'hAAAAA};
    table_rows.push_back(r);
    foreach (table_rows[i]) send_reading(table_rows[i].rd, table_rows[i].has_known,
                                         table_rows[i].known);
    drain();

    load_typical();
    table_rows.delete();
    r.has_known = 0;
    r.rd = '{20'd519888, 20'd415148};
    table_rows.push_back(r);
    r.rd = '{20'd0, 20'd0};
    table_rows.push_back(r);
    r.rd = '{20'hFFFFF, 20'hFFFFF};
    table_rows.push_back(r);
    r.rd = '{20'hFFFFF, 20'd0};
    table_rows.push_back(r);
    r.rd = '{20'd0, 20'hFFFFF};
    table_rows.push_back(r);
    r.rd = '{20'd1, 20'd1};
    table_rows.push_back(r);
    r.rd = '{20'd400000, 20'd300000};
    table_rows.push_back(r);
    r.rd = '{20'd600000, 20'd600000};
    table_rows.push_back(r);
    foreach (table_rows[i]) send_reading(table_rows[i].rd, 0, r.known);
    drain();

    // Scale extremes: zero scale forces pascals to 0 without the flag.
    write_reg(bsc_pkg::REG_SEA_SCALE, 64'd0);
    send_reading('{20'd519888, 20'd415148}, 0, r.known);
    drain();
    write_reg(bsc_pkg::REG_SEA_SCALE, 64'd200000);
    send_reading('{20'd519888, 20'd415148}, 0, r.known);
    send_reading('{20'd0, 20'hFFFFF}, 0, r.known);
    drain();

    // Long receiver hold-off while readings keep coming, to back the pipeline up.
    write_reg(bsc_pkg::REG_SEA_SCALE, {46'd0, bsc_pkg::SCALE_RESET});
    hold_off = 600;
    random_burst(200);
    drain();

    random_burst(500);
    drain();

    // Random calibration words, extreme words included.
    for (int k = 0; k < 12; k++) begin
      write_reg(bsc_pkg::REG_TEMP_CALIB, {$urandom, $urandom});
      write_reg(bsc_pkg::REG_PRESS_LOW, {$urandom, $urandom});
      write_reg(bsc_pkg::REG_PRESS_HIGH, {$urandom, $urandom});
      write_reg(bsc_pkg::REG_PRESS_LAST, {$urandom, $urandom});
      write_reg(bsc_pkg::REG_SEA_SCALE, 64'($urandom_range(0, 200000)));
      random_burst(60);
      drain();
    end
    write_reg(bsc_pkg::REG_TEMP_CALIB, {64{1'b1}});
    write_reg(bsc_pkg::REG_PRESS_LOW, {64{1'b1}});
    write_reg(bsc_pkg::REG_PRESS_HIGH, {64{1'b1}});
    write_reg(bsc_pkg::REG_PRESS_LAST, {64{1'b1}});
    write_reg(bsc_pkg::REG_SEA_SCALE, 64'd200000);
    random_burst(100);
    drain();
    write_reg(bsc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
    write_reg(bsc_pkg::REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
    write_reg(bsc_pkg::REG_PRESS_LAST, 64'h8000);
    random_burst(100);
    drain();
    load_typical();
    write_reg(bsc_pkg::REG_SEA_SCALE, {46'd0, bsc_pkg::SCALE_RESET});
    random_burst(300);
    s_tvalid <= 1'b0;

    guard = 0;
    while (pending_readings.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (PIPE_LATENCY + 20) @(negedge clk);
    if (fail_count == 0 && pending_readings.size() == 0)
      $display("barometric_sensor_compensation test passed");
    else
      $display("barometric_sensor_compensation test failed");
    $finish;
  end

endmodule
